[sv/fcsf_pkg.sv]
`timescale 1ns / 1ps
package fcsf_pkg;

   localparam int COUNT_W       = 8;
   localparam int GAP_W         = 9;
   localparam int CUTOFF_W      = 24;
   localparam int SEQ_W         = 32;
   localparam int POS_W         = 32;
   localparam int COV_W         = 40;
   localparam int SUM_W         = 18;
   localparam int PROD_W        = COUNT_W + SUM_W;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_GAP_RESET = 300;

   typedef enum logic [1:0] {
      CSR_MIN_GAP    = 2'd0,
      CSR_MAX_GAP    = 2'd1,
      CSR_CUTOFF     = 2'd2,
      CSR_SEQ_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] fwd_count;
      logic [COUNT_W-1:0] rev_count;
      logic               final_item;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] summit_pos;
      logic [COV_W-1:0] summit_cov;
   } rsp_payload_type;

   // one ring slot: counts of a position plus the reverse count of the position before
   typedef struct packed {
      logic [COUNT_W-1:0] rev_prev;
      logic [COUNT_W-1:0] rev;
      logic [COUNT_W-1:0] fwd;
   } ring_word_type;

endpackage

[sv/fcsf_ring.sv]
`timescale 1ns / 1ps
module fcsf_ring #(
   parameter int WINDOW = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic                                 clear,
   input  logic [$clog2(WINDOW)-1:0]            wr_addr,
   input  fcsf_pkg::ring_word_type              wr_word,
   input  logic                                 rd_en,
   input  logic [$clog2(WINDOW)-1:0]            rd_addr_a,
   input  logic [$clog2(WINDOW)-1:0]            rd_addr_b,
   input  logic [$clog2(WINDOW)-1:0]            rd_addr_c,
   input  logic [$clog2(WINDOW)-1:0]            rd_addr_d,
   output fcsf_pkg::ring_word_type              rd_word_a,
   output fcsf_pkg::ring_word_type              rd_word_b,
   output logic [fcsf_pkg::COUNT_W-1:0]         rd_fwd_c,
   output logic [fcsf_pkg::COUNT_W-1:0]         rd_fwd_d
);

   localparam int AW = $clog2(WINDOW);

   fcsf_pkg::ring_word_type      word_mem [WINDOW];
   logic [fcsf_pkg::COUNT_W-1:0] fwd_mem  [WINDOW];

   logic [AW:0] fill_ff;
   logic [AW:0] fill_in;

   fcsf_pkg::ring_word_type      word_a_ff;
   fcsf_pkg::ring_word_type      word_b_ff;
   logic [fcsf_pkg::COUNT_W-1:0] fwd_c_ff;
   logic [fcsf_pkg::COUNT_W-1:0] fwd_d_ff;
   logic                         ok_a_ff;
   logic                         ok_b_ff;
   logic                         ok_c_ff;
   logic                         ok_d_ff;

   // slots are filled in order after a clear, so a slot below the fill count holds live data
   always_comb begin
      fill_in = fill_ff;
      if (wr_en) begin
         if (clear) begin
            fill_in = '0;
         end else if (fill_ff != (AW + 1)'(WINDOW)) begin
            fill_in = fill_ff + (AW + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         word_a_ff <= word_mem[rd_addr_a];
         word_b_ff <= word_mem[rd_addr_b];
         ok_a_ff   <= {1'b0, rd_addr_a} < fill_ff;
         ok_b_ff   <= {1'b0, rd_addr_b} < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_mem[wr_addr] <= wr_word.fwd;
      end
      if (rd_en) begin
         fwd_c_ff <= fwd_mem[rd_addr_c];
         fwd_d_ff <= fwd_mem[rd_addr_d];
         ok_c_ff  <= {1'b0, rd_addr_c} < fill_ff;
         ok_d_ff  <= {1'b0, rd_addr_d} < fill_ff;
      end
   end

   assign rd_word_a = ok_a_ff ? word_a_ff : '0;
   assign rd_word_b = ok_b_ff ? word_b_ff : '0;
   assign rd_fwd_c  = ok_c_ff ? fwd_c_ff : '0;
   assign rd_fwd_d  = ok_d_ff ? fwd_d_ff : '0;

endmodule

[sv/fragment_coverage_summit_finder.sv]
`timescale 1ns / 1ps
// Fragment coverage summit finder. One position per clock: a request is taken every
// cycle while the request side is not stalled, and a summit for the position max_gap
// behind it passes through the ring read, window sums, products, coverage and summit
// check, then the output register. The counts live in two ring memories of WINDOW slots
// (WINDOW must be a power of two, at least 2*max_gap+2 for exact coverage), each
// written once and read twice per request; a fill counter stands in for clearing
// them, so there is no clearing pass after reset or after the final request. The
// request side stalls only when a summit at the last stage meets a result that is
// still waiting in the output register.
module fragment_coverage_summit_finder #(
   parameter int WINDOW = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fcsf_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fcsf_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_we,
   input  fcsf_pkg::csr_index_type           csr_index,
   input  logic [fcsf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(WINDOW);

   typedef struct packed {
      logic [fcsf_pkg::COUNT_W-1:0] fwd_count;
      logic [fcsf_pkg::COUNT_W-1:0] rev_count;
      logic                         final_item;
      logic [fcsf_pkg::POS_W-1:0]   x;
      logic                         in_range;
      logic                         gap_ok;
      logic                         use_prev;
      logic [fcsf_pkg::COUNT_W-1:0] rev_prev;
   } s1_type;

   typedef struct packed {
      logic [fcsf_pkg::COUNT_W-1:0] fwd_x;
      logic [fcsf_pkg::COUNT_W-1:0] rev_xm1;
      logic [fcsf_pkg::SUM_W-1:0]   rev_sum;
      logic [fcsf_pkg::SUM_W-1:0]   fwd_sum;
      logic                         gap_ok;
      logic                         final_item;
      logic [fcsf_pkg::POS_W-1:0]   x;
      logic                         in_range;
   } s2_type;

   typedef struct packed {
      logic [fcsf_pkg::PROD_W-1:0] gain;
      logic [fcsf_pkg::PROD_W-1:0] loss;
      logic                        gap_ok;
      logic                        final_item;
      logic [fcsf_pkg::POS_W-1:0]  x;
      logic                        in_range;
   } s3_type;

   typedef struct packed {
      logic [fcsf_pkg::COV_W-1:0] cov;
      logic [fcsf_pkg::COV_W-1:0] prev;
      logic [fcsf_pkg::COV_W-1:0] prev2;
      logic [fcsf_pkg::POS_W-1:0] x;
      logic                       in_range;
      logic                       final_item;
   } s4_type;

   // configuration
   logic [fcsf_pkg::GAP_W-1:0]    min_gap_ff;
   logic [fcsf_pkg::GAP_W-1:0]    max_gap_ff;
   logic [fcsf_pkg::CUTOFF_W-1:0] cutoff_ff;
   logic [fcsf_pkg::SEQ_W-1:0]    seq_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff    <= '0;
         max_gap_ff    <= fcsf_pkg::GAP_W'(fcsf_pkg::MAX_GAP_RESET);
         cutoff_ff     <= '0;
         seq_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fcsf_pkg::CSR_MIN_GAP:    min_gap_ff    <= csr_wdata[fcsf_pkg::GAP_W-1:0];
            fcsf_pkg::CSR_MAX_GAP:    max_gap_ff    <= csr_wdata[fcsf_pkg::GAP_W-1:0];
            fcsf_pkg::CSR_CUTOFF:     cutoff_ff     <= csr_wdata[fcsf_pkg::CUTOFF_W-1:0];
            fcsf_pkg::CSR_SEQ_LENGTH: seq_length_ff <= csr_wdata[fcsf_pkg::SEQ_W-1:0];
         endcase
      end
   end

   // pipeline control
   logic adv;
   logic accept;
   logic emit;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;
   logic rsp_valid_ff;

   s1_type s1_ff;
   s2_type s2_ff;
   s3_type s3_ff;
   s4_type s4_ff;
   fcsf_pkg::rsp_payload_type rsp_data_ff;

   assign adv       = !(emit && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 0: ring access
   logic [fcsf_pkg::POS_W-1:0]   idx_ff;
   logic [fcsf_pkg::POS_W-1:0]   idx_in;
   logic [fcsf_pkg::COUNT_W-1:0] rev_prev_ff;
   logic [fcsf_pkg::COUNT_W-1:0] rev_prev_in;
   logic [fcsf_pkg::POS_W-1:0]   mx_ext;
   logic [fcsf_pkg::POS_W-1:0]   mn_ext;
   logic [fcsf_pkg::POS_W:0]     x_wide;
   logic [fcsf_pkg::POS_W-1:0]   pos_a;
   logic [fcsf_pkg::POS_W-1:0]   pos_b;
   logic [fcsf_pkg::POS_W-1:0]   pos_c;
   logic [fcsf_pkg::POS_W-1:0]   pos_d;
   logic                         in_range;
   logic                         gap_ok;
   logic                         use_prev;
   fcsf_pkg::ring_word_type      wr_word;
   fcsf_pkg::ring_word_type      ring_word_a;
   fcsf_pkg::ring_word_type      ring_word_b;
   logic [fcsf_pkg::COUNT_W-1:0] ring_fwd_c;
   logic [fcsf_pkg::COUNT_W-1:0] ring_fwd_d;

   always_comb begin
      mx_ext   = fcsf_pkg::POS_W'(max_gap_ff);
      mn_ext   = fcsf_pkg::POS_W'(min_gap_ff);
      x_wide   = {1'b0, idx_ff} - {1'b0, mx_ext};
      in_range = !x_wide[fcsf_pkg::POS_W]
                 && (x_wide[fcsf_pkg::POS_W-1:0] > fcsf_pkg::POS_W'(1))
                 && (x_wide[fcsf_pkg::POS_W-1:0] < seq_length_ff);
      gap_ok   = min_gap_ff < max_gap_ff;
      // max_gap a multiple of the ring depth: the packed previous reverse count is stale
      use_prev = mx_ext[AW-1:0] == '0;
      pos_a    = idx_ff - mx_ext;
      pos_b    = idx_ff - mx_ext + mn_ext;
      pos_c    = idx_ff - mx_ext - mn_ext - fcsf_pkg::POS_W'(2);
      pos_d    = idx_ff - {mx_ext[fcsf_pkg::POS_W-2:0], 1'b0} - fcsf_pkg::POS_W'(2);
      wr_word  = '{rev_prev: rev_prev_ff, rev: req_data.rev_count, fwd: req_data.fwd_count};
      idx_in      = idx_ff;
      rev_prev_in = rev_prev_ff;
      if (accept) begin
         idx_in      = req_data.final_item ? '0 : idx_ff + fcsf_pkg::POS_W'(1);
         rev_prev_in = req_data.final_item ? '0 : req_data.rev_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         rev_prev_ff <= '0;
      end else begin
         idx_ff      <= idx_in;
         rev_prev_ff <= rev_prev_in;
      end
   end

   fcsf_ring #(
      .WINDOW (WINDOW)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .clear     (req_data.final_item),
      .wr_addr   (idx_ff[AW-1:0]),
      .wr_word   (wr_word),
      .rd_en     (adv),
      .rd_addr_a (pos_a[AW-1:0]),
      .rd_addr_b (pos_b[AW-1:0]),
      .rd_addr_c (pos_c[AW-1:0]),
      .rd_addr_d (pos_d[AW-1:0]),
      .rd_word_a (ring_word_a),
      .rd_word_b (ring_word_b),
      .rd_fwd_c  (ring_fwd_c),
      .rd_fwd_d  (ring_fwd_d)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= '{fwd_count:  req_data.fwd_count,
                    rev_count:  req_data.rev_count,
                    final_item: req_data.final_item,
                    x:          x_wide[fcsf_pkg::POS_W-1:0],
                    in_range:   in_range,
                    gap_ok:     gap_ok,
                    use_prev:   use_prev,
                    rev_prev:   rev_prev_ff};
      end
   end

   // stage 1: sliding window sums
   logic [fcsf_pkg::SUM_W-1:0]   rev_sum_ff;
   logic [fcsf_pkg::SUM_W-1:0]   fwd_sum_ff;
   logic [fcsf_pkg::SUM_W-1:0]   rev_sum_in;
   logic [fcsf_pkg::SUM_W-1:0]   fwd_sum_in;
   logic [fcsf_pkg::SUM_W-1:0]   rev_sum_new;
   logic [fcsf_pkg::SUM_W-1:0]   fwd_sum_new;
   logic [fcsf_pkg::COUNT_W-1:0] rev_xm1;

   always_comb begin
      rev_xm1 = s1_ff.use_prev ? s1_ff.rev_prev : ring_word_a.rev_prev;
      if (s1_ff.gap_ok) begin
         rev_sum_new = rev_sum_ff + fcsf_pkg::SUM_W'(s1_ff.rev_count)
                       - fcsf_pkg::SUM_W'(ring_word_b.rev);
         fwd_sum_new = fwd_sum_ff + fcsf_pkg::SUM_W'(ring_fwd_c)
                       - fcsf_pkg::SUM_W'(ring_fwd_d);
      end else begin
         rev_sum_new = '0;
         fwd_sum_new = '0;
      end
      rev_sum_in = rev_sum_ff;
      fwd_sum_in = fwd_sum_ff;
      if (adv && s1_valid_ff) begin
         rev_sum_in = s1_ff.final_item ? '0 : rev_sum_new;
         fwd_sum_in = s1_ff.final_item ? '0 : fwd_sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_sum_ff <= '0;
         fwd_sum_ff <= '0;
      end else begin
         rev_sum_ff <= rev_sum_in;
         fwd_sum_ff <= fwd_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= '{fwd_x:      ring_word_a.fwd,
                    rev_xm1:    rev_xm1,
                    rev_sum:    rev_sum_new,
                    fwd_sum:    fwd_sum_new,
                    gap_ok:     s1_ff.gap_ok,
                    final_item: s1_ff.final_item,
                    x:          s1_ff.x,
                    in_range:   s1_ff.in_range};
      end
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= '{gain:       fcsf_pkg::PROD_W'(s2_ff.fwd_x) * fcsf_pkg::PROD_W'(s2_ff.rev_sum),
                    loss:       fcsf_pkg::PROD_W'(s2_ff.rev_xm1) * fcsf_pkg::PROD_W'(s2_ff.fwd_sum),
                    gap_ok:     s2_ff.gap_ok,
                    final_item: s2_ff.final_item,
                    x:          s2_ff.x,
                    in_range:   s2_ff.in_range};
      end
   end

   // stage 3: coverage
   logic [fcsf_pkg::COV_W-1:0] cov_prev_ff;
   logic [fcsf_pkg::COV_W-1:0] cov_prev2_ff;
   logic [fcsf_pkg::COV_W-1:0] cov_prev_in;
   logic [fcsf_pkg::COV_W-1:0] cov_prev2_in;
   logic [fcsf_pkg::COV_W-1:0] cov_new;

   always_comb begin
      if (s3_ff.gap_ok) begin
         cov_new = cov_prev_ff + fcsf_pkg::COV_W'(s3_ff.gain) - fcsf_pkg::COV_W'(s3_ff.loss);
      end else begin
         cov_new = cov_prev_ff;
      end
      cov_prev_in  = cov_prev_ff;
      cov_prev2_in = cov_prev2_ff;
      if (adv && s3_valid_ff) begin
         cov_prev_in  = s3_ff.final_item ? '0 : cov_new;
         cov_prev2_in = s3_ff.final_item ? '0 : cov_prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cov_prev_ff  <= '0;
         cov_prev2_ff <= '0;
      end else begin
         cov_prev_ff  <= cov_prev_in;
         cov_prev2_ff <= cov_prev2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff <= '{cov:        cov_new,
                    prev:       cov_prev_ff,
                    prev2:      cov_prev2_ff,
                    x:          s3_ff.x,
                    in_range:   s3_ff.in_range,
                    final_item: s3_ff.final_item};
      end
   end

   // stage 4: plateau tracking and summit
   logic [fcsf_pkg::POS_W-1:0] plateau_start_ff;
   logic [fcsf_pkg::POS_W-1:0] plateau_start_in;
   logic                       rising_ff;
   logic                       rising_in;
   logic [fcsf_pkg::POS_W-1:0] start_eff;
   logic [fcsf_pkg::POS_W-1:0] pos_span;
   logic [fcsf_pkg::POS_W-1:0] summit_pos;
   logic                       rise;
   logic                       rising_eff;

   always_comb begin
      rise       = s4_ff.in_range && (s4_ff.prev2 < s4_ff.prev);
      start_eff  = rise ? s4_ff.x - fcsf_pkg::POS_W'(1) : plateau_start_ff;
      rising_eff = rise || rising_ff;
      emit       = s4_valid_ff && s4_ff.in_range && rising_eff
                   && (s4_ff.prev > s4_ff.cov)
                   && (fcsf_pkg::COV_W'(cutoff_ff) < s4_ff.prev);
      pos_span   = s4_ff.x - start_eff;
      summit_pos = start_eff + {1'b0, pos_span[fcsf_pkg::POS_W-1:1]};
      plateau_start_in = plateau_start_ff;
      rising_in        = rising_ff;
      if (adv && s4_valid_ff) begin
         if (s4_ff.final_item) begin
            plateau_start_in = '0;
            rising_in        = 1'b0;
         end else if (s4_ff.in_range) begin
            plateau_start_in = start_eff;
            rising_in        = rising_eff && !emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plateau_start_ff <= '0;
         rising_ff        <= 1'b0;
      end else begin
         plateau_start_ff <= plateau_start_in;
         rising_ff        <= rising_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         rsp_data_ff <= '{summit_pos: summit_pos, summit_cov: s4_ff.prev};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rising_drops_after_summit: assert property (
      @(posedge clock) disable iff (reset)
      adv && emit |=> !rising_ff
   ) else $error("plateau still open after a summit");

   a_cov_cleared_after_final: assert property (
      @(posedge clock) disable iff (reset)
      adv && s3_valid_ff && s3_ff.final_item |=> cov_prev_ff == '0 && cov_prev2_ff == '0
   ) else $error("coverage history not cleared after the final request");

   a_index_restarts_after_final: assert property (
      @(posedge clock) disable iff (reset)
      accept && req_data.final_item |=> idx_ff == '0 && rev_prev_ff == '0
   ) else $error("position index not restarted after the final request");
`endif

endmodule
